// ===== rtl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

  // Longest index the buffers may reach; the indices never pass 255.
  localparam int LEN_MAX = 255;
  localparam logic [7:0] IDX_LIMIT = 8'((LEN_MAX < 255) ? LEN_MAX : 255);

  // Input item kinds.
  localparam logic FUNC_BEGIN  = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDRESS_BYTE = 2'd0;
  localparam logic [1:0] CFG_WRITE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_READ_LENGTH  = 2'd2;

  // Status codes of the I2C core.
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_REP_START  = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  // Transfer phases.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_STARTED   = 3'd1;
  localparam logic [2:0] PH_RESTARTED = 3'd2;
  localparam logic [2:0] PH_REPSTART  = 3'd3;
  localparam logic [2:0] PH_DATA_ACK  = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  typedef struct packed {
    logic       func;
    logic [7:0] status;
    logic [7:0] rx_data;
    logic [7:0] tx_data;
  } in_item_t;

  typedef struct packed {
    logic       dat_write;
    logic [7:0] dat_value;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_ack;
    logic       clear_start;
    logic       clear_si;
    logic       rx_store;
    logic [7:0] rx_index;
    logic [7:0] tx_index;
    logic [2:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] tx_pos;
    logic [7:0] rx_pos;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] write_length;
    logic [7:0] read_length;
  } seq_cfg_t;

  // Saturating increment of a buffer index.
  function automatic logic [7:0] bump(input logic [7:0] v);
    bump = (v < IDX_LIMIT) ? v + 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cms_decode.sv =====
`default_nettype none

module i2cms_decode
  import i2cms_pkg::*;
(
  input  wire in_item_t   item,
  input  wire seq_state_t cur,
  input  wire seq_cfg_t   cfg,
  output out_item_t       res,
  output seq_state_t      nxt
);

  logic [7:0] tx_bump;
  logic [7:0] rx_bump;

  assign tx_bump = bump(cur.tx_pos);
  assign rx_bump = bump(cur.rx_pos);

  // Decode one transaction into control actions and the next sequencer state.
  always_comb begin
    res = '0;
    nxt = cur;
    if (item.func == FUNC_BEGIN) begin
      nxt.phase     = PH_IDLE;
      nxt.tx_pos    = '0;
      nxt.rx_pos    = '0;
      res.set_start = 1'b1;
    end else begin
      res.clear_si = 1'b1;
      unique case (item.status) inside
        ST_START: begin
          nxt.tx_pos      = '0;
          res.dat_write   = 1'b1;
          res.dat_value   = cfg.address_byte;
          res.clear_start = 1'b1;
          nxt.phase       = PH_STARTED;
        end
        ST_REP_START: begin
          nxt.rx_pos      = '0;
          res.dat_write   = 1'b1;
          res.dat_value   = cfg.address_byte;
          res.clear_start = 1'b1;
          nxt.phase       = PH_RESTARTED;
        end
        ST_SLAW_ACK: begin
          // Only the started phase sends the first data byte.
          if (cur.phase == PH_STARTED) begin
            res.dat_write = 1'b1;
            res.dat_value = item.tx_data;
            nxt.tx_pos    = tx_bump;
            nxt.phase     = PH_DATA_ACK;
          end
        end
        ST_DATA_ACK, ST_DATA_NACK: begin
          if (cur.tx_pos < cfg.write_length) begin
            res.dat_write = 1'b1;
            res.dat_value = item.tx_data;
            nxt.tx_pos    = tx_bump;
            nxt.phase     = PH_DATA_ACK;
          end else if (cfg.read_length != 8'd0) begin
            res.set_start = 1'b1;
            nxt.phase     = PH_REPSTART;
          end else begin
            res.set_stop = 1'b1;
            nxt.phase    = PH_DONE;
          end
        end
        ST_SLAR_ACK: begin
          if (cfg.read_length == 8'd1) res.clear_ack = 1'b1;
          else res.set_ack = 1'b1;
        end
        ST_RX_ACK: begin
          res.rx_store = 1'b1;
          res.rx_index = cur.rx_pos;
          nxt.rx_pos   = rx_bump;
          if (rx_bump < cfg.read_length) begin
            nxt.phase   = PH_DATA_ACK;
            res.set_ack = 1'b1;
          end else begin
            nxt.phase     = PH_DONE;
            res.clear_ack = 1'b1;
          end
        end
        ST_RX_NACK: begin
          res.rx_store = 1'b1;
          res.rx_index = cur.rx_pos;
          nxt.rx_pos   = rx_bump;
          nxt.phase    = PH_DONE;
          res.set_stop = 1'b1;
        end
        ST_SLAW_NACK, ST_SLAR_NACK: begin
          nxt.phase = PH_DONE;
        end
        default: begin
          // Arbitration lost and unknown codes only release the core.
        end
      endcase
      // Entering the done phase ends the transfer with a stop.
      if (nxt.phase == PH_DONE && cur.phase != PH_DONE) begin
        res.set_stop = 1'b1;
      end
    end
    res.tx_index = nxt.tx_pos;
    res.phase    = nxt.phase;
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer_unit.sv =====
`default_nettype none

// Sequences one I2C master transfer from the status codes of an I2C core. A begin
// transaction (func 0) restarts from idle and requests a start; each status transaction
// returns exactly one result with the data register load, the start, stop and acknowledge
// controls, the receive store position, the next transmit index and the phase. The block
// takes one transaction per cycle while in_stall is low. An accepted transaction sits in the
// input register, passes through the status decode and is captured in the result register
// once that register is free, and its result is then offered from it. While a result is held
// by out_stall and the input register is full, in_stall follows out_stall in the same
// cycle. Configuration writes are taken in any cycle (cfg_ready is always high) but must
// be made while no transaction is in flight.
module i2c_master_transfer_sequencer_unit
  import i2cms_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire             out_stall,
  output out_item_t       out_item,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [1:0]       cfg_index,
  input  wire [7:0]       cfg_data
);

  seq_cfg_t   cfg_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  in_item_t   s1_item_r;
  logic       s1_valid_r;
  out_item_t  result;
  logic       out_free;
  logic       s1_move;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADDRESS_BYTE: cfg_r.address_byte <= cfg_data;
        CFG_WRITE_LENGTH: cfg_r.write_length <= cfg_data;
        CFG_READ_LENGTH:  cfg_r.read_length  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control.
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  i2cms_decode u_decode (
    .item (s1_item_r),
    .cur  (state_r),
    .cfg  (cfg_r),
    .res  (result),
    .nxt  (state_nxt)
  );

  // Sequencer state advances as each transaction leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, tx_pos: 8'd0, rx_pos: 8'd0};
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cms_checker.sv =====
`default_nettype none

module i2cms_checker
  import i2cms_pkg::*;
(
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_stall,
  input wire in_item_t  in_item,
  input wire            out_valid,
  input wire            out_stall,
  input wire out_item_t out_item,
  input wire            cfg_valid,
  input wire            cfg_ready,
  input wire [1:0]      cfg_index,
  input wire [7:0]      cfg_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // The input side only stalls when a result is held up downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A stop always ends the transfer in the done phase and releases the core.
  a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.set_stop |-> out_item.phase == PH_DONE && out_item.clear_si)
    else $error("stop outside the done phase");

  // No data value without a data load, no store position without a store.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.dat_write || out_item.dat_value == 8'd0)
                  && (out_item.rx_store || out_item.rx_index == 8'd0))
    else $error("unused result field not zero");

endmodule

bind i2c_master_transfer_sequencer_unit i2cms_checker u_checker (.*);

`default_nettype wire
